FILE: src/idxa_pkg.sv
// ----------------------------------------------------------------------------
// Index allocator package
// Shared widths, register map, command and status codes for the slot index
// allocator and its checker.
// ----------------------------------------------------------------------------
package idxa_pkg;

    localparam int IDX_W    = 10;   // slot index and growth size
    localparam int CFG_W    = 11;   // start capacity register
    localparam int STATUS_W = 2;

    localparam int DEFAULT_MAX_SLOTS = 1024;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Word index of the start capacity register (byte address / 4).
    localparam logic [APB_AW-3:0] REG_START_CAPACITY = '0;

    localparam logic [CFG_W-1:0] START_CAP_RESET = 11'd64;

    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_EXHAUSTED  = 2'd1,
        STATUS_STACK_FULL = 2'd2
    } status_t;

endpackage

FILE: src/idxa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module idxa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/index_allocator_free_stack.sv
// ----------------------------------------------------------------------------
// Slot index allocator with bump count and free stack
// Hands out table slot indices and takes them back.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (s_*) carries a command word: acquire, or release of
// s_release_index. The result channel (m_*) returns exactly one word per
// request, in order: the granted index, a status, and the growth size.
// An acquire is served from the never-used slots first, then from the free
// stack (most recent release first), then by doubling the capacity if it fits, else it fails as exhausted.
// m_valid rises once a result word has passed the stage after acceptance and
// been written into the result queue; one request is accepted every cycle
// while s_ready is high. The free stack lives in a RAM with a registered read
// port, so a pop resolves its index in the stage after acceptance.
// A two-word result queue holds results while the receiver stalls; s_ready
// drops only when the queue and the stage ahead of it are both committed.
// Reset empties the pipeline, sets start_capacity to 64 and restarts the
// allocator; a write of start_capacity on the APB port also restarts it.
// Stack contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module index_allocator_free_stack #(
    parameter int MAX_SLOTS = idxa_pkg::DEFAULT_MAX_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [idxa_pkg::APB_AW-1:0]   paddr,
    input  logic [idxa_pkg::APB_DW-1:0]   pwdata,
    output logic [idxa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [idxa_pkg::IDX_W-1:0]    s_release_index,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [idxa_pkg::IDX_W-1:0]    m_granted_index,
    output idxa_pkg::status_t             m_status,
    output logic [idxa_pkg::IDX_W-1:0]    m_grow_amount
);
    import idxa_pkg::*;

    localparam int CW         = $clog2(MAX_SLOTS + 1);
    localparam int AW         = $clog2(MAX_SLOTS);
    localparam int EXW        = (CW > IDX_W) ? CW : IDX_W;
    localparam int CLW        = (CW > CFG_W) ? CW : CFG_W;
    localparam int HALF_SLOTS = MAX_SLOTS / 2;

    typedef struct packed {
        logic [IDX_W-1:0] grant;
        status_t          status;
        logic [IDX_W-1:0] grow;
    } result_t;

    function automatic logic [CW-1:0] clamp_cap(input logic [CFG_W-1:0] v);
        logic [CLW-1:0] w;
        w = CLW'(v);
        if (w == '0) begin
            w = CLW'(1);
        end else if (w > CLW'(MAX_SLOTS)) begin
            w = CLW'(MAX_SLOTS);
        end
        return w[CW-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] fit_idx(input logic [CW-1:0] v);
        logic [EXW-1:0] w;
        w = EXW'(v);
        return w[IDX_W-1:0];
    endfunction

    // Configuration
    logic [CFG_W-1:0] start_cap_reg;
    logic             cfg_sel;
    logic             cfg_write;
    logic [CW-1:0]    eff_new;

    // Allocator state
    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] unused_reg, unused_next;
    logic [CW-1:0] free_reg, free_next;
    logic [CW-1:0] free_m1;

    // Request decode
    logic             accept;
    logic [IDX_W-1:0] res_grant;
    status_t          res_status;
    logic [IDX_W-1:0] res_grow;
    logic             res_pop;
    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_rdata;

    // Stage after acceptance
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_grant_reg;
    status_t          s1_status_reg;
    logic [IDX_W-1:0] s1_grow_reg;
    logic             s1_pop_reg;
    result_t          s1_result;

    // Result queue
    result_t    q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] q_count_reg, q_count_next;
    logic       q_pop;

    assign cfg_sel   = (paddr[APB_AW-1:2] == REG_START_CAPACITY);
    assign cfg_write = psel && penable && pwrite && cfg_sel;
    assign eff_new   = clamp_cap(pwdata[CFG_W-1:0]);
    assign pready    = 1'b1;
    assign prdata    = cfg_sel ? APB_DW'(start_cap_reg) : '0;

    assign accept  = s_valid && s_ready;
    assign free_m1 = free_reg - 1'b1;

    always_comb begin
        cap_next    = cap_reg;
        unused_next = unused_reg;
        free_next   = free_reg;
        res_grant   = '0;
        res_status  = STATUS_OK;
        res_grow    = '0;
        res_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        if (cfg_write) begin
            cap_next    = eff_new;
            unused_next = eff_new;
            free_next   = '0;
        end else if (accept) begin
            if (s_command == CMD_RELEASE) begin
                if (free_reg >= cap_reg) begin
                    res_status = STATUS_STACK_FULL;
                end else begin
                    ram_we    = 1'b1;
                    free_next = free_reg + 1'b1;
                end
            end else if (unused_reg != '0) begin
                res_grant   = fit_idx(cap_reg - unused_reg);
                unused_next = unused_reg - 1'b1;
            end else if (free_reg != '0) begin
                // Index arrives from the RAM in the next stage.
                ram_re    = 1'b1;
                res_pop   = 1'b1;
                free_next = free_m1;
            end else if (cap_reg > CW'(HALF_SLOTS)) begin
                res_status = STATUS_EXHAUSTED;
            end else begin
                res_grant   = fit_idx(cap_reg);
                res_grow    = fit_idx(cap_reg);
                unused_next = cap_reg - 1'b1;
                cap_next    = cap_reg << 1;
            end
        end
    end

    idxa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_SLOTS)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_reg[AW-1:0]),
        .wdata (s_release_index),
        .re    (ram_re),
        .raddr (free_m1[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign s1_result.grant  = s1_pop_reg ? ram_rdata : s1_grant_reg;
    assign s1_result.status = s1_status_reg;
    assign s1_result.grow   = s1_grow_reg;

    // The queue plus the stage ahead never hold more than two words.
    assign m_valid      = (q_count_reg != 2'd0);
    assign q_pop        = m_valid && m_ready;
    assign q_count_next = q_count_reg - {1'b0, q_pop} + {1'b0, s1_valid_reg};
    assign s_ready      = (q_count_next < 2'd2);

    assign m_granted_index = q_mem_reg[rd_ptr_reg].grant;
    assign m_status        = q_mem_reg[rd_ptr_reg].status;
    assign m_grow_amount   = q_mem_reg[rd_ptr_reg].grow;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_cap_reg <= START_CAP_RESET;
            cap_reg       <= clamp_cap(START_CAP_RESET);
            unused_reg    <= clamp_cap(START_CAP_RESET);
            free_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            q_count_reg   <= 2'd0;
        end else begin
            if (cfg_write) begin
                start_cap_reg <= pwdata[CFG_W-1:0];
            end
            cap_reg      <= cap_next;
            unused_reg   <= unused_next;
            free_reg     <= free_next;
            s1_valid_reg <= accept;
            q_count_reg  <= q_count_next;
            if (s1_valid_reg) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_grant_reg  <= res_grant;
            s1_status_reg <= res_status;
            s1_grow_reg   <= res_grow;
            s1_pop_reg    <= res_pop;
        end
        if (s1_valid_reg) begin
            q_mem_reg[wr_ptr_reg] <= s1_result;
        end
    end

endmodule

FILE: src/idxa_checker.sv
// ----------------------------------------------------------------------------
// Index allocator port checker
// Watches the result channel for handshake and result consistency.
// ----------------------------------------------------------------------------
module idxa_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [idxa_pkg::IDX_W-1:0] m_granted_index,
    input idxa_pkg::status_t          m_status,
    input logic [idxa_pkg::IDX_W-1:0] m_grow_amount
);
    import idxa_pkg::*;

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_index)
            && $stable(m_status) && $stable(m_grow_amount))
        else $error("result word changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Failed requests carry neither an index nor a growth.
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_EXHAUSTED || m_status == STATUS_STACK_FULL)
            |-> m_granted_index == '0 && m_grow_amount == '0)
        else $error("failed request reports an index or growth");

    // A growth grants the first new slot, which equals the old capacity.
    a_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_grow_amount != '0
            |-> m_status == STATUS_OK && m_granted_index == m_grow_amount)
        else $error("growth result inconsistent");

endmodule

bind index_allocator_free_stack idxa_checker u_idxa_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_granted_index (m_granted_index),
    .m_status        (m_status),
    .m_grow_amount   (m_grow_amount)
);

FILE: verif/idxa_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot index allocator scoreboard
// Predicts the result word of every accepted request, keeps the expected
// words in order and compares them field by field with what the block returns.
// ----------------------------------------------------------------------------
package idxa_scoreboard_pkg;

    import idxa_pkg::*;

    localparam int MAX_SLOTS = DEFAULT_MAX_SLOTS;

    typedef struct {
        logic [IDX_W-1:0] granted_index;
        status_t          status;
        logic [IDX_W-1:0] grow_amount;
    } alloc_result_t;

    class alloc_scoreboard;

        logic [CFG_W-1:0] start_capacity;
        int unsigned      capacity_now;
        int unsigned      unused_count;
        int unsigned      free_count;
        logic [IDX_W-1:0] free_stack [MAX_SLOTS];

        alloc_result_t    expected_results [$];

        int unsigned      errors;
        int unsigned      n_requests;
        int unsigned      n_bump;
        int unsigned      n_pop;
        int unsigned      n_grow;
        int unsigned      n_exhausted;
        int unsigned      n_pushed;
        int unsigned      n_rejected;
        int unsigned      n_settings;

        function new();
            start_capacity = START_CAP_RESET;
            restart_allocator();
        endfunction

        // The register keeps all 11 bits, the allocator uses the clamped value.
        function void restart_allocator();
            int unsigned cap;
            cap = start_capacity;
            if (cap < 1) cap = 1;
            if (cap > MAX_SLOTS) cap = MAX_SLOTS;
            capacity_now = cap;
            unused_count = cap;
            free_count   = 0;
        endfunction

        function void set_start_capacity(input logic [CFG_W-1:0] value);
            start_capacity = value;
            n_settings++;
            restart_allocator();
        endfunction

        function void report_mismatch(input string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endfunction

        function int unsigned pending_count();
            return expected_results.size();
        endfunction

        function void note_request(input command_t cmd, input logic [IDX_W-1:0] rel_index);
            alloc_result_t exp_word;
            exp_word.granted_index = '0;
            exp_word.status        = STATUS_OK;
            exp_word.grow_amount   = '0;
            n_requests++;
            if (cmd == CMD_ACQUIRE) begin
                if (unused_count > 0) begin
                    exp_word.granted_index = IDX_W'(capacity_now - unused_count);
                    unused_count--;
                    n_bump++;
                end else if (free_count > 0) begin
                    free_count--;
                    exp_word.granted_index = free_stack[free_count];
                    n_pop++;
                end else if (2 * capacity_now > MAX_SLOTS) begin
                    exp_word.status = STATUS_EXHAUSTED;
                    n_exhausted++;
                end else begin
                    // Doubling: the first new slot is granted right away.
                    exp_word.granted_index = IDX_W'(capacity_now);
                    exp_word.grow_amount   = IDX_W'(capacity_now);
                    unused_count = capacity_now - 1;
                    capacity_now = 2 * capacity_now;
                    n_grow++;
                end
            end else begin
                if (free_count >= capacity_now || free_count >= MAX_SLOTS) begin
                    exp_word.status = STATUS_STACK_FULL;
                    n_rejected++;
                end else begin
                    free_stack[free_count] = rel_index;
                    free_count++;
                    n_pushed++;
                end
            end
            expected_results.push_back(exp_word);
        endfunction

        function void check_result(input logic [IDX_W-1:0] granted_index,
                                   input status_t status,
                                   input logic [IDX_W-1:0] grow_amount);
            alloc_result_t exp_word;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result word with no request waiting: idx %0d st %0d",
                                          granted_index, status));
                return;
            end
            exp_word = expected_results.pop_front();
            if (granted_index !== exp_word.granted_index)
                report_mismatch($sformatf("granted_index %0d, expected %0d",
                                          granted_index, exp_word.granted_index));
            if (status !== exp_word.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          status, exp_word.status));
            if (grow_amount !== exp_word.grow_amount)
                report_mismatch($sformatf("grow_amount %0d, expected %0d",
                                          grow_amount, exp_word.grow_amount));
        endfunction

    endclass

endpackage

FILE: verif/index_allocator_free_stack_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot index allocator testbench
// Drives acquire and release words with random gaps and stalls on both
// channels, reprograms the start capacity between phases and checks every
// result word against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module index_allocator_free_stack_test;

    import idxa_pkg::*;
    import idxa_scoreboard_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_STALL   = 80;
    localparam int RANDOM_ITEMS = 250;
    localparam int SWEEP_LIMIT  = 1600;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [APB_AW-1:0]   paddr           = '0;
    logic [APB_DW-1:0]   pwdata          = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic                s_command       = 1'b0;
    logic [IDX_W-1:0]    s_release_index = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [IDX_W-1:0]    m_granted_index;
    status_t             m_status;
    logic [IDX_W-1:0]    m_grow_amount;

    alloc_scoreboard     sb;
    bit                  no_idle       = 1'b0;
    bit                  stall_request = 1'b0;
    int unsigned         idle_cycles   = 0;

    index_allocator_free_stack uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_release_index (s_release_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_index (m_granted_index),
        .m_status        (m_status),
        .m_grow_amount   (m_grow_amount)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic offer_request(input command_t cmd, input logic [IDX_W-1:0] idx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_release_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(cmd, idx);
    endtask

    task automatic random_request(input int release_pct);
        command_t cmd;
        cmd = ($urandom_range(0, 99) < release_pct) ? CMD_RELEASE : CMD_ACQUIRE;
        offer_request(cmd, IDX_W'($urandom()));
    endtask

    // Lowers valid at the step of the last acceptance, then lets the block drain.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write then read back; psel stays high from the write into the read.
    task automatic program_start_capacity(input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_START_CAPACITY, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_start_capacity(value[CFG_W-1:0]);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== APB_DW'(value[CFG_W-1:0]))
            sb.report_mismatch($sformatf("start_capacity reads %0d, expected %0d",
                                         prdata, value[CFG_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_results();
        int hold;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 5);
            if (stall_request) begin
                hold += LONG_STALL;
                stall_request = 1'b0;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_result(m_granted_index, m_status, m_grow_amount);
        end
    endtask

    initial begin
        int unsigned first_caps [6];
        int unsigned random_done;
        int unsigned phase;
        int unsigned n_items;
        int unsigned sweep_items;
        int unsigned exhausted_mark;
        int          release_pct;
        logic [CFG_W-1:0] cap;

        first_caps = '{1, 1024, 2, 64, 3, 512};
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            drain_results();
        join_none

        // Reset capacity of 64: bump grants, then releases at both index extremes.
        offer_request(CMD_ACQUIRE, 10'h3FF);
        offer_request(CMD_ACQUIRE, 10'h000);
        offer_request(CMD_RELEASE, 10'h3FF);
        offer_request(CMD_RELEASE, 10'h000);
        offer_request(CMD_ACQUIRE, 10'h155);
        wait_idle();

        // Zero clamps to one slot: growth, a full stack, pops in reverse order.
        program_start_capacity(32'd0);
        offer_request(CMD_ACQUIRE, 10'h000);
        offer_request(CMD_ACQUIRE, 10'h000);
        offer_request(CMD_RELEASE, 10'h2AA);
        offer_request(CMD_RELEASE, 10'h155);
        offer_request(CMD_RELEASE, 10'h3FF);
        offer_request(CMD_ACQUIRE, 10'h000);
        offer_request(CMD_ACQUIRE, 10'h000);
        offer_request(CMD_ACQUIRE, 10'h000);
        offer_request(CMD_ACQUIRE, 10'h000);
        offer_request(CMD_ACQUIRE, 10'h000);
        wait_idle();

        // All ones clamps to the maximum; bump slots win over the free stack.
        program_start_capacity(32'h0000_07FF);
        offer_request(CMD_ACQUIRE, 10'h000);
        offer_request(CMD_RELEASE, 10'h005);
        offer_request(CMD_ACQUIRE, 10'h000);
        wait_idle();

        random_done = 0;
        phase       = 0;
        while (random_done < RANDOM_ITEMS) begin
            if (phase < 6)
                cap = CFG_W'(first_caps[phase]);
            else if ($urandom_range(0, 3) == 0)
                cap = CFG_W'($urandom_range(0, 2047));
            else
                cap = CFG_W'($urandom_range(1, 16));
            program_start_capacity(APB_DW'(cap));
            case ($urandom_range(0, 2))
                0:       release_pct = 15;
                1:       release_pct = 50;
                default: release_pct = 85;
            endcase
            no_idle = (phase % 4 == 1);
            // One phase backs the block up against a stalled receiver.
            if (phase == 2) begin
                stall_request = 1'b1;
                release_pct   = 50;
            end
            n_items = $urandom_range(30, 70);
            for (int i = 0; i < n_items; i++) begin
                if (phase == 3 && i == n_items / 2)
                    wait_idle();
                random_request(release_pct);
            end
            random_done += n_items;
            wait_idle();
            no_idle = 1'b0;
            phase++;
        end

        // From 33 slots, mostly acquires: four doublings up to 528 slots,
        // then exhaustion, with a few releases popped back in between.
        program_start_capacity(32'd33);
        exhausted_mark = sb.n_exhausted;
        sweep_items    = 0;
        while (sb.n_exhausted < exhausted_mark + 4 && sweep_items < SWEEP_LIMIT) begin
            random_request(5);
            sweep_items++;
        end
        offer_request(CMD_RELEASE, 10'h3FF);
        offer_request(CMD_ACQUIRE, 10'h000);
        offer_request(CMD_ACQUIRE, 10'h000);
        wait_idle();
        repeat (10) @(posedge aclk);

        if (sb.pending_count() != 0)
            sb.report_mismatch($sformatf("%0d result words never arrived",
                                         sb.pending_count()));
        $display("Ran %0d requests over %0d start capacity settings.",
                 sb.n_requests, sb.n_settings);
        $display("Bump %0d, pop %0d, grow %0d, exhausted %0d, pushed %0d, rejected %0d.",
                 sb.n_bump, sb.n_pop, sb.n_grow, sb.n_exhausted, sb.n_pushed,
                 sb.n_rejected);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
src/idxa_pkg.sv
src/idxa_ram.sv
src/index_allocator_free_stack.sv
src/idxa_checker.sv
verif/idxa_scoreboard_pkg.sv
verif/index_allocator_free_stack_test.sv
